// ----- design/block_range_add_range_sum_assert.svh -----
// Assertion macros shared by the range add / range sum block.
`ifndef BLOCK_RANGE_ADD_RANGE_SUM_ASSERT_SVH
`define BLOCK_RANGE_ADD_RANGE_SUM_ASSERT_SVH

`ifndef SYNTHESIS
`define BRARS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define BRARS_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define BRARS_ASSERT(name, clk, rst, prop)
`define BRARS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- design/brars_pkg.sv -----
// Constants, codes and control types of the range add / range sum block.
package brars_pkg;

   localparam int MAX_ELEMENTS = 65536;
   localparam int BLOCK_SIZE   = 256;
   localparam int NUM_BLOCKS   = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;

   localparam int FUNC_W = 2;
   localparam int IDX_W  = 16;
   localparam int AMT_W  = 32;
   localparam int SUM_W  = 64;
   localparam int CFG_W  = 17;

   localparam int OFF_W     = $clog2(BLOCK_SIZE);
   localparam int ELEM_AW   = $clog2(MAX_ELEMENTS);
   localparam int BLK_AW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int BLK_DEPTH = 2 ** BLK_AW;
   localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
   localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   localparam logic [CFG_W-1:0] CFG_COUNT_RESET = CFG_W'(65536);

   localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SUM  = 2'd2;

   typedef struct packed {
      logic capture;
      logic walk_lo;
      logic walk_hi;
      logic elem_step;
      logic blk_step;
      logic pend_read;
      logic load_write;
      logic bsum_rmw;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              err;
      logic              single;
      logic              has_middle;
      logic              walk_last;
      logic              blk_last;
   } sts_type;

endpackage

// ----- design/brars_if.sv -----
// Request and response channel interfaces.
interface brars_req_if;
   import brars_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic [IDX_W-1:0]        range_low;
   logic [IDX_W-1:0]        range_high;
   logic signed [AMT_W-1:0] amount;

   modport source (output valid, func, range_low, range_high, amount, input ready);
   modport sink (input valid, func, range_low, range_high, amount, output ready);
endinterface

interface brars_rsp_if;
   import brars_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] range_sum;
   logic                    range_error;

   modport source (output valid, range_sum, range_error, input ready);
   modport sink (input valid, range_sum, range_error, output ready);
endinterface

// ----- design/block_range_add_range_sum.sv -----
// Top level of the block-decomposed range add / range sum engine.
// One item is worked at a time. A load writes its element and starts its block sum
// update in the decode state, then shows its result once the response side is free.
// A range add or range query walks its partial end blocks one element per cycle through
// the element memory read port, then visits every whole block in between one per cycle
// through the block sum and pending add memories. Rejected items go from decode straight
// to the finish state and answer with the error flag and a zero sum.
// A new request is taken while the previous result still waits on the response side.
// Block sums and pending adds read as zero after reset through per-block valid bits, so
// there is no clearing pass; the element store is undefined until each index is loaded.
// The element count register may be written only while the block is idle.
module block_range_add_range_sum (
   input  logic                        clock,
   input  logic                        reset,
   brars_req_if.sink                   req_ch,
   brars_rsp_if.source                 rsp_ch,
   input  logic                        csr_write_enable,
   input  logic [brars_pkg::CFG_W-1:0] csr_write_data
);
   import brars_pkg::*;

`include "block_range_add_range_sum_assert.svh"

   cmd_type          cmd;
   sts_type          sts;
   logic             req_ready;
   logic             rsp_valid;
   logic [SUM_W-1:0] rsp_sum;

   brars_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   brars_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_func         (req_ch.func),
      .req_range_low    (req_ch.range_low),
      .req_range_high   (req_ch.range_high),
      .req_amount       (req_ch.amount),
      .rsp_range_sum    (rsp_sum),
      .rsp_range_error  (rsp_ch.range_error)
   );

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid;
   assign rsp_ch.range_sum = rsp_sum;

   `BRARS_ASSERT(a_busy_after_transfer, clock, reset, cmd.capture |=> !req_ch.ready)
   `BRARS_ASSERT(a_finish_shows_result, clock, reset, cmd.finish |=> rsp_ch.valid)
   `BRARS_ASSERT(a_error_zero_sum, clock, reset,
      (rsp_ch.valid && rsp_ch.range_error) |-> (rsp_ch.range_sum == '0))
   `BRARS_ASSERT_ALWAYS(a_one_sequencer_cmd, clock,
      $onehot0({cmd.capture, cmd.elem_step, cmd.blk_step, cmd.finish}))

endmodule

// ----- design/brars_ram.sv -----
// Generic one-write one-read RAM with registered read data.
module brars_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/brars_ctrl.sv -----
// Sequencer: walks load, range add and range query through the datapath.
module brars_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  brars_pkg::sts_type sts,
   output brars_pkg::cmd_type cmd
);
   import brars_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_WALK   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_BSUM   = 3'd4;
   localparam logic [2:0] ST_BLK    = 3'd5;
   localparam logic [2:0] ST_INIT_C = 3'd6;
   localparam logic [2:0] ST_FIN    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] after_walk;

   always_comb begin
      if (phase_ff || sts.single) begin
         after_walk = ST_FIN;
      end else if (sts.has_middle) begin
         after_walk = ST_BLK;
      end else begin
         after_walk = ST_INIT_C;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      phase_in  = phase_ff;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            phase_in = 1'b0;
            if (sts.err) begin
               state_in = ST_FIN;
            end else begin
               case (sts.func)
                  FUNC_LOAD: begin
                     cmd.load_write = 1'b1;
                     cmd.bsum_rmw   = 1'b1;
                     state_in       = ST_FIN;
                  end
                  FUNC_ADD: begin
                     cmd.walk_lo = 1'b1;
                     state_in    = ST_WALK;
                  end
                  FUNC_SUM: begin
                     cmd.walk_lo   = 1'b1;
                     cmd.pend_read = 1'b1;
                     state_in      = ST_WALK;
                  end
                  default: state_in = ST_FIN;
               endcase
            end
         end
         ST_WALK: begin
            cmd.elem_step = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (sts.func == FUNC_ADD) begin
               state_in = ST_BSUM;
            end else begin
               state_in = after_walk;
            end
         end
         ST_BSUM: begin
            cmd.bsum_rmw = 1'b1;
            state_in     = after_walk;
         end
         ST_BLK: begin
            cmd.blk_step = 1'b1;
            if (sts.blk_last) begin
               state_in = ST_INIT_C;
            end
         end
         ST_INIT_C: begin
            cmd.walk_hi   = 1'b1;
            cmd.pend_read = (sts.func == FUNC_SUM);
            phase_in      = 1'b1;
            state_in      = ST_WALK;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/brars_dp.sv -----
// Datapath: item registers, element and block memories, walk counters, sums.
module brars_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  brars_pkg::cmd_type                 cmd,
   output brars_pkg::sts_type                 sts,
   input  logic                               csr_write_enable,
   input  logic [brars_pkg::CFG_W-1:0]        csr_write_data,
   input  logic [brars_pkg::FUNC_W-1:0]       req_func,
   input  logic [brars_pkg::IDX_W-1:0]        req_range_low,
   input  logic [brars_pkg::IDX_W-1:0]        req_range_high,
   input  logic signed [brars_pkg::AMT_W-1:0] req_amount,
   output logic [brars_pkg::SUM_W-1:0]        rsp_range_sum,
   output logic                               rsp_range_error
);
   import brars_pkg::*;

   logic [CFG_W-1:0]   csr_count_ff, csr_count_in;
   logic [CMP_W-1:0]   count_act, lo_w, hi_w;
   logic               err_now;

   logic [FUNC_W-1:0]  func_ff, func_in;
   logic               err_ff, err_in;
   logic [ELEM_AW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [SUM_W-1:0]   amt_ff, amt_in;
   logic [BLK_AW-1:0]  bl_ff, bl_in, bh_ff, bh_in;
   logic [BLK_AW-1:0]  cur_blk_ff, cur_blk_in;
   logic [BLK_AW-1:0]  blk_ptr_ff, blk_ptr_in, blk_end_ff, blk_end_in;
   logic [ELEM_AW-1:0] rd_addr_ff, rd_addr_in, rd_end_ff, rd_end_in;
   logic [SUM_W-1:0]   elem_acc_ff, elem_acc_in, aux_acc_ff, aux_acc_in;
   logic [SUM_W-1:0]   pend_hold_ff, pend_hold_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               tag_elem_ff, tag_blk_ff, tag_pend_ff, tag_bsum_ff;
   logic [ELEM_AW-1:0] elem_wr_addr_ff;
   logic [BLK_AW-1:0]  pend_wr_addr_ff, bsum_wr_addr_ff;

   logic [BLK_DEPTH-1:0] pend_valid_ff, pend_valid_in;
   logic [BLK_DEPTH-1:0] bsum_valid_ff, bsum_valid_in;
   logic                 pend_vq_ff, bsum_vq_ff;

   logic               elem_wr_en, pend_wr_en, bsum_wr_en;
   logic [ELEM_AW-1:0] elem_wr_addr;
   logic [SUM_W-1:0]   elem_wr_data, pend_wr_data, bsum_wr_data;
   logic [SUM_W-1:0]   elem_q, pend_q, bsum_q, pend_val, bsum_val;
   logic               pend_rd_en, bsum_rd_en;
   logic [BLK_AW-1:0]  pend_rd_addr, bsum_rd_addr;
   logic [ELEM_AW-1:0] cap_lo, cap_hi;
   logic               is_add, is_sum;

   // range checks against the active element count
   always_comb begin
      count_act = (CMP_W'(csr_count_ff) > CMP_W'(MAX_ELEMENTS)) ?
                  CMP_W'(MAX_ELEMENTS) : CMP_W'(csr_count_ff);
      lo_w = CMP_W'(req_range_low);
      hi_w = CMP_W'(req_range_high);
      case (req_func)
         FUNC_LOAD: err_now = (lo_w >= count_act);
         FUNC_ADD,
         FUNC_SUM:  err_now = (lo_w > hi_w) || (hi_w >= count_act);
         default:   err_now = 1'b1;
      endcase
      cap_lo = ELEM_AW'(req_range_low);
      cap_hi = ELEM_AW'(req_range_high);
   end

   assign is_add   = (func_ff == FUNC_ADD);
   assign is_sum   = (func_ff == FUNC_SUM);
   assign pend_val = pend_vq_ff ? pend_q : '0;
   assign bsum_val = bsum_vq_ff ? bsum_q : '0;

   // memory ports
   always_comb begin
      elem_wr_en   = cmd.load_write | (tag_elem_ff & is_add);
      elem_wr_addr = cmd.load_write ? lo_ff : elem_wr_addr_ff;
      elem_wr_data = cmd.load_write ? amt_ff : elem_q + amt_ff;

      pend_wr_en   = tag_blk_ff & is_add;
      pend_wr_data = pend_val + amt_ff;
      pend_rd_en   = cmd.blk_step | cmd.pend_read;
      if (cmd.blk_step) begin
         pend_rd_addr = blk_ptr_ff;
      end else if (cmd.walk_hi) begin
         pend_rd_addr = bh_ff;
      end else begin
         pend_rd_addr = cur_blk_ff;
      end

      bsum_wr_en   = tag_bsum_ff;
      bsum_wr_data = bsum_val + ((func_ff == FUNC_LOAD) ? amt_ff : aux_acc_ff);
      bsum_rd_en   = cmd.blk_step | cmd.bsum_rmw;
      bsum_rd_addr = cmd.blk_step ? blk_ptr_ff : cur_blk_ff;
   end

   brars_ram #(.WIDTH(SUM_W), .DEPTH(2 ** ELEM_AW)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_en   (cmd.elem_step),
      .rd_addr (rd_addr_ff),
      .rd_data (elem_q)
   );

   brars_ram #(.WIDTH(SUM_W), .DEPTH(BLK_DEPTH)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_wr_en),
      .wr_addr (pend_wr_addr_ff),
      .wr_data (pend_wr_data),
      .rd_en   (pend_rd_en),
      .rd_addr (pend_rd_addr),
      .rd_data (pend_q)
   );

   brars_ram #(.WIDTH(SUM_W), .DEPTH(BLK_DEPTH)) u_bsum_ram (
      .clock   (clock),
      .wr_en   (bsum_wr_en),
      .wr_addr (bsum_wr_addr_ff),
      .wr_data (bsum_wr_data),
      .rd_en   (bsum_rd_en),
      .rd_addr (bsum_rd_addr),
      .rd_data (bsum_q)
   );

   // next-state logic
   always_comb begin
      csr_count_in  = csr_write_enable ? csr_write_data : csr_count_ff;
      func_in       = func_ff;
      err_in        = err_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      amt_in        = amt_ff;
      bl_in         = bl_ff;
      bh_in         = bh_ff;
      cur_blk_in    = cur_blk_ff;
      blk_ptr_in    = blk_ptr_ff;
      blk_end_in    = blk_end_ff;
      rd_addr_in    = rd_addr_ff;
      rd_end_in     = rd_end_ff;
      elem_acc_in   = elem_acc_ff;
      aux_acc_in    = aux_acc_ff;
      pend_hold_in  = pend_hold_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_err_in    = rsp_err_ff;
      pend_valid_in = pend_valid_ff;
      bsum_valid_in = bsum_valid_ff;

      if (cmd.capture) begin
         func_in     = req_func;
         err_in      = err_now;
         lo_in       = cap_lo;
         hi_in       = cap_hi;
         amt_in      = SUM_W'(req_amount);
         bl_in       = BLK_AW'(cap_lo >> OFF_W);
         bh_in       = BLK_AW'(cap_hi >> OFF_W);
         cur_blk_in  = BLK_AW'(cap_lo >> OFF_W);
         blk_ptr_in  = BLK_AW'(cap_lo >> OFF_W) + BLK_AW'(1);
         blk_end_in  = BLK_AW'(cap_hi >> OFF_W) - BLK_AW'(1);
         elem_acc_in = '0;
         aux_acc_in  = '0;
      end

      if (cmd.walk_lo) begin
         rd_addr_in = lo_ff;
         rd_end_in  = sts.single ? hi_ff : ELEM_AW'({bl_ff, {OFF_W{1'b1}}});
         if (is_add) begin
            aux_acc_in = '0;
         end
      end
      if (cmd.walk_hi) begin
         rd_addr_in = ELEM_AW'({bh_ff, {OFF_W{1'b0}}});
         rd_end_in  = hi_ff;
         cur_blk_in = bh_ff;
         if (is_add) begin
            aux_acc_in = '0;
         end
      end
      if (cmd.elem_step) begin
         rd_addr_in = rd_addr_ff + ELEM_AW'(1);
      end
      if (cmd.blk_step) begin
         blk_ptr_in = blk_ptr_ff + BLK_AW'(1);
      end

      if (tag_elem_ff) begin
         if (is_add) begin
            aux_acc_in = aux_acc_ff + amt_ff;
         end else begin
            elem_acc_in = elem_acc_ff + elem_q;
            aux_acc_in  = aux_acc_ff + pend_hold_ff;
         end
      end
      if (tag_blk_ff && is_sum) begin
         elem_acc_in = elem_acc_ff + bsum_val;
         aux_acc_in  = aux_acc_ff + (pend_val << OFF_W);
      end
      if (tag_pend_ff) begin
         pend_hold_in = pend_val;
      end

      if (pend_wr_en) begin
         pend_valid_in[pend_wr_addr_ff] = 1'b1;
      end
      if (bsum_wr_en) begin
         bsum_valid_in[bsum_wr_addr_ff] = 1'b1;
      end

      if (cmd.finish) begin
         rsp_sum_in = (!err_ff && is_sum) ? elem_acc_ff + aux_acc_ff : '0;
         rsp_err_in = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff  <= CFG_COUNT_RESET;
         pend_valid_ff <= '0;
         bsum_valid_ff <= '0;
         pend_vq_ff    <= 1'b0;
         bsum_vq_ff    <= 1'b0;
         tag_elem_ff   <= 1'b0;
         tag_blk_ff    <= 1'b0;
         tag_pend_ff   <= 1'b0;
         tag_bsum_ff   <= 1'b0;
      end else begin
         csr_count_ff  <= csr_count_in;
         pend_valid_ff <= pend_valid_in;
         bsum_valid_ff <= bsum_valid_in;
         if (pend_rd_en) begin
            pend_vq_ff <= pend_valid_ff[pend_rd_addr];
         end
         if (bsum_rd_en) begin
            bsum_vq_ff <= bsum_valid_ff[bsum_rd_addr];
         end
         tag_elem_ff   <= cmd.elem_step;
         tag_blk_ff    <= cmd.blk_step;
         tag_pend_ff   <= cmd.pend_read;
         tag_bsum_ff   <= cmd.bsum_rmw;
      end
   end

   always_ff @(posedge clock) begin
      func_ff         <= func_in;
      err_ff          <= err_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      amt_ff          <= amt_in;
      bl_ff           <= bl_in;
      bh_ff           <= bh_in;
      cur_blk_ff      <= cur_blk_in;
      blk_ptr_ff      <= blk_ptr_in;
      blk_end_ff      <= blk_end_in;
      rd_addr_ff      <= rd_addr_in;
      rd_end_ff       <= rd_end_in;
      elem_acc_ff     <= elem_acc_in;
      aux_acc_ff      <= aux_acc_in;
      pend_hold_ff    <= pend_hold_in;
      rsp_sum_ff      <= rsp_sum_in;
      rsp_err_ff      <= rsp_err_in;
      elem_wr_addr_ff <= rd_addr_ff;
      pend_wr_addr_ff <= blk_ptr_ff;
      bsum_wr_addr_ff <= cur_blk_ff;
   end

   always_comb begin
      sts.func       = func_ff;
      sts.err        = err_ff;
      sts.single     = (bl_ff == bh_ff);
      sts.has_middle = (BLK_AW + 1)'(bh_ff) > ((BLK_AW + 1)'(bl_ff) + (BLK_AW + 1)'(1));
      sts.walk_last  = (rd_addr_ff == rd_end_ff);
      sts.blk_last   = (blk_ptr_ff == blk_end_ff);
   end

   assign rsp_range_sum   = rsp_sum_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule
